@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

    // command field codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // status field codes
    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_DELIVERED = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int ID_W   = 16;
    localparam int PAGE_W = 16;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted input item
        logic exec;   // update the cells and load the result register
    } t_dp_cmd;

endpackage

@@ rtl/core/spq_if.sv @@
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for queue commands and queue results.
// ----------------------------------------------------------------------------
interface spq_in_if
    import spq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [ID_W-1:0]   job_id;
    logic [PAGE_W-1:0] page_count;
    logic [PRIO_W-1:0] job_priority;

    modport source (output valid, command, job_id, page_count, job_priority,
                    input ready);
    modport sink   (input valid, command, job_id, page_count, job_priority,
                    output ready);
endinterface

interface spq_out_if
    import spq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   out_id;
    logic [PAGE_W-1:0] out_pages;
    logic [PRIO_W-1:0] out_priority;
    logic [OCC_W-1:0]  occupancy;

    modport source (output valid, status, out_id, out_pages, out_priority,
                    occupancy, input ready);
    modport sink   (input valid, status, out_id, out_pages, out_priority,
                    occupancy, output ready);
endinterface

@@ rtl/core/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake sequencer: accept, execute, present result.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    assign in_xfer = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_in_valid ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                // next item may enter as the result leaves
                o_in_ready  = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.load = in_xfer;
    end

endmodule

@@ rtl/core/spq_dp.sv @@
// ----------------------------------------------------------------------------
// spq_dp
// Sorted cell chain with input capture and result register.
// ----------------------------------------------------------------------------
module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic              i_command,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [PAGE_W-1:0] i_page_count,
    input  logic [PRIO_W-1:0] i_job_priority,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_out_id,
    output logic [PAGE_W-1:0] o_out_pages,
    output logic [PRIO_W-1:0] o_out_priority,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    // captured item
    logic              r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [PAGE_W-1:0] r_pages;
    logic [PRIO_W-1:0] r_prio;

    // cells, index 0 is the head
    logic [ID_W-1:0]   r_cell_id   [CAPACITY];
    logic [PAGE_W-1:0] r_cell_pages[CAPACITY];
    logic [PRIO_W-1:0] r_cell_prio [CAPACITY];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    logic [CAPACITY-1:0] greater;   // occupied and strictly lower rank
    logic [CAPACITY-1:0] ins;       // cell takes part in the insert shift

    logic is_full;
    logic is_empty;
    logic do_enq;
    logic do_deq;

    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign do_enq   = i_cmd.exec && (r_cmd == CMD_ENQUEUE) && !is_full;
    assign do_deq   = i_cmd.exec && (r_cmd == CMD_DEQUEUE) && !is_empty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_id    <= i_job_id;
            r_pages <= i_page_count;
            r_prio  <= i_job_priority;
        end
    end

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            assign greater[k] = (CW'(k) < r_count) && (r_cell_prio[k] > r_prio);
            assign ins[k]     = greater[k] || (CW'(k) == r_count);

            always_ff @(posedge i_clk) begin
                if (do_enq && ins[k]) begin
                    if ((k > 0) && greater[(k > 0) ? k - 1 : 0]) begin
                        r_cell_id[k]    <= r_cell_id[(k > 0) ? k - 1 : 0];
                        r_cell_pages[k] <= r_cell_pages[(k > 0) ? k - 1 : 0];
                        r_cell_prio[k]  <= r_cell_prio[(k > 0) ? k - 1 : 0];
                    end else begin
                        r_cell_id[k]    <= r_id;
                        r_cell_pages[k] <= r_pages;
                        r_cell_prio[k]  <= r_prio;
                    end
                end else if (do_deq && (k < CAPACITY - 1)) begin
                    // cells past the count pick up don't-care data
                    r_cell_id[k]    <= r_cell_id[(k < CAPACITY - 1) ? k + 1 : k];
                    r_cell_pages[k] <= r_cell_pages[(k < CAPACITY - 1) ? k + 1 : k];
                    r_cell_prio[k]  <= r_cell_prio[(k < CAPACITY - 1) ? k + 1 : k];
                end
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (do_enq) begin
            n_count = r_count + CW'(1);
        end else if (do_deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register, loaded while the cells update
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_out_id       <= '0;
            o_out_pages    <= '0;
            o_out_priority <= '0;
            o_occupancy    <= OCC_W'(n_count);
            if (r_cmd == CMD_ENQUEUE) begin
                o_status <= is_full ? ST_FULL : ST_ACCEPTED;
            end else if (is_empty) begin
                o_status <= ST_EMPTY;
            end else begin
                o_status       <= ST_DELIVERED;
                o_out_id       <= r_cell_id[0];
                o_out_pages    <= r_cell_pages[0];
                o_out_priority <= r_cell_prio[0];
            end
        end
    end

endmodule

@@ rtl/core/stable_priority_queue_core.sv @@
// A bounded, stable priority queue of jobs. Each command transfer on i_in
// yields exactly one result transfer on o_out. An enqueue places the job
// behind every queued job whose priority value is lower or equal, so jobs
// of equal priority leave in arrival order; a full queue drops the job and
// reports full. A dequeue returns the head job and removes it; an empty
// queue reports empty. Occupancy is the count after the command, modulo 32.
// Each command is captured into the input register on its transfer; in the
// EXEC state the cell chain compares every entry against the new priority in
// parallel and shifts. A result waiting on o_out holds off the input, and the
// next command is taken in the cycle the result leaves, so a new command is
// not taken before the previous result is gone. No clearing pass follows reset;
// the queue is empty at once.
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Top level: controller, cell-chain datapath and channel hookup.
// ----------------------------------------------------------------------------
module stable_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    spq_in_if.sink  i_in,
    spq_out_if.source o_out
);

    t_dp_cmd cmd;

    // sequencer: IDLE -> EXEC -> OUT, OUT may go straight to EXEC
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // sorted cells plus input capture and result register
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_command      (i_in.command),
        .i_job_id       (i_in.job_id),
        .i_page_count   (i_in.page_count),
        .i_job_priority (i_in.job_priority),
        .o_status       (o_out.status),
        .o_out_id       (o_out.out_id),
        .o_out_pages    (o_out.out_pages),
        .o_out_priority (o_out.out_priority),
        .o_occupancy    (o_out.occupancy)
    );

endmodule

@@ tb/stable_priority_queue_core_tb.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_core_tb
// Self-checking bench for the stable priority queue core. A short table of
// directed commands covers the field extremes, empty and full queues and
// runs of equal priorities; about nine hundred random commands follow under
// three idle patterns, two long result hold-offs and drain pauses. A shadow
// queue predicts every result, and each result transfer is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module stable_priority_queue_core_tb;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Q_DEPTH     = 16;
    localparam int RAND_ITEMS  = 300;      // per idle pattern, three patterns
    localparam int LONG_HOLD   = 300;      // result side hold-off, cycles
    localparam int MAX_GAP     = 24;       // cap on one sender gap
    localparam int TAIL_CYCLES = 10;       // settle time after the last result
    localparam int CYCLE_LIMIT = 400000;

    // one command transfer and one result transfer
    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   id;
        logic [PAGE_W-1:0] pages;
        logic [PRIO_W-1:0] prio;
    } t_job_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id;
        logic [PAGE_W-1:0] pages;
        logic [PRIO_W-1:0] prio;
        logic [OCC_W-1:0]  occupancy;
    } t_job_res;

    // directed row: a command and, where it is obvious, the result typed in
    typedef struct {
        t_job_cmd job;
        bit       known;
        t_job_res res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    spq_in_if  cmd_if ();
    spq_out_if res_if ();

    stable_priority_queue_core #(
        .CAPACITY (Q_DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // shadow copy of the queue, head at index 0
    logic [ID_W-1:0]   shadow_id    [Q_DEPTH];
    logic [PAGE_W-1:0] shadow_pages [Q_DEPTH];
    logic [PRIO_W-1:0] shadow_prio  [Q_DEPTH];
    int                shadow_count;

    t_job_res results_due [$];   // predictions not yet matched by a result
    t_dir_row dir_rows    [$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req_seq  = 0;       // bumped to ask the receiver for a hold-off

    // ------------------------------------------------------------------------
    // Clock, 2 ns period
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** stable_priority_queue_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor: one command in, the result it must produce out.
    // Enqueue goes behind every entry with a lower or equal priority value.
    // ------------------------------------------------------------------------
    function automatic t_job_res queue_step(input t_job_cmd job);
        t_job_res r;
        int       pos;
        r = '0;
        if (job.cmd == CMD_ENQUEUE) begin
            if (shadow_count >= Q_DEPTH) begin
                r.status = ST_FULL;          // job dropped
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= job.prio)
                    pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_id[k]    = shadow_id[k-1];
                    shadow_pages[k] = shadow_pages[k-1];
                    shadow_prio[k]  = shadow_prio[k-1];
                end
                shadow_id[pos]    = job.id;
                shadow_pages[pos] = job.pages;
                shadow_prio[pos]  = job.prio;
                shadow_count++;
                r.status = ST_ACCEPTED;
            end
        end else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status = ST_DELIVERED;
            r.id     = shadow_id[0];
            r.pages  = shadow_pages[0];
            r.prio   = shadow_prio[0];
            for (int k = 1; k < shadow_count; k++) begin
                shadow_id[k-1]    = shadow_id[k];
                shadow_pages[k-1] = shadow_pages[k];
                shadow_prio[k-1]  = shadow_prio[k];
            end
            shadow_count--;
        end
        r.occupancy = OCC_W'(shadow_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready pattern, with a long hold-off when asked.
    // The hold counter lives here so the sender keeps offering meanwhile.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && hold_seen != hold_req_seq) begin
                hold_seen = hold_req_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, want, got);
        mismatches++;
    endtask

    // Result monitor, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_job_res want;
        t_job_res got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.status    = res_if.status;
            got.id        = res_if.out_id;
            got.pages     = res_if.out_pages;
            got.prio      = res_if.out_priority;
            got.occupancy = res_if.occupancy;
            if (results_due.size() == 0) begin
                $display("%0t: result transfer with none expected, actual 0x%0h",
                         $time, got);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (got.status !== want.status)
                    flag_field("status", 32'(want.status), 32'(got.status));
                if (got.id !== want.id)
                    flag_field("out_id", 32'(want.id), 32'(got.id));
                if (got.pages !== want.pages)
                    flag_field("out_pages", 32'(want.pages), 32'(got.pages));
                if (got.prio !== want.prio)
                    flag_field("out_priority", 32'(want.prio), 32'(got.prio));
                if (got.occupancy !== want.occupancy)
                    flag_field("occupancy", 32'(want.occupancy),
                               32'(got.occupancy));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    // Offer one command after a random gap; on the transfer edge the
    // prediction is queued. A typed-in result, when given, replaces it.
    // valid is left high after the transfer; the next call or drop_and_drain
    // decides at the next falling edge.
    task automatic send_job(input t_job_cmd job, input bit known,
                            input t_job_res res);
        int       gap;
        t_job_res predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= job.cmd;
        cmd_if.job_id       <= job.id;
        cmd_if.page_count   <= job.pages;
        cmd_if.job_priority <= job.prio;
        do @(posedge i_clk); while (!cmd_if.ready);
        predicted = queue_step(job);
        results_due.push_back(known ? res : predicted);
    endtask

    // Stop offering, then wait for every outstanding result.
    task automatic drop_and_drain();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Random command; the enqueue share sets the drift toward full or empty.
    function automatic t_job_cmd rand_job(input int enq_pct);
        t_job_cmd j;
        j.cmd   = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
        j.id    = ID_W'($urandom);
        j.pages = PAGE_W'($urandom);
        case ($urandom_range(3))
            0:       j.prio = PRIO_W'($urandom_range(3));     // many ties
            1:       j.prio = $urandom_range(1) ? '1 : '0;    // extremes
            default: j.prio = PRIO_W'($urandom);
        endcase
        return j;
    endfunction

    function automatic void add_row(input t_job_cmd job, input bit known,
                                    input t_job_res res);
        t_dir_row row;
        row.job   = job;
        row.known = known;
        row.res   = res;
        dir_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [PRIO_W-1:0] fill_prio [Q_DEPTH];
        int                enq_pct;

        fill_prio = '{8'd5, 8'd3, 8'd5, 8'd0, 8'd255, 8'd3, 8'd7, 8'd5,
                      8'd0, 8'd255, 8'd128, 8'd3, 8'd5, 8'd1, 8'd254, 8'd5};

        i_rst_n             = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.command      = CMD_ENQUEUE;
        cmd_if.job_id       = '0;
        cmd_if.page_count   = '0;
        cmd_if.job_priority = '0;
        shadow_count        = 0;

        // Directed table. Typed-in results: dequeue from empty after reset,
        // all-ones and all-zero jobs in and straight out, enqueue into full.
        add_row({CMD_DEQUEUE, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
                {ST_EMPTY, 16'h0, 16'h0, 8'h0, 5'd0});
        add_row({CMD_ENQUEUE, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
                {ST_ACCEPTED, 16'h0, 16'h0, 8'h0, 5'd1});
        add_row({CMD_DEQUEUE, 16'h0, 16'h0, 8'h0}, 1'b1,
                {ST_DELIVERED, 16'hFFFF, 16'hFFFF, 8'hFF, 5'd0});
        add_row({CMD_ENQUEUE, 16'h0, 16'h0, 8'h0}, 1'b1,
                {ST_ACCEPTED, 16'h0, 16'h0, 8'h0, 5'd1});
        add_row({CMD_DEQUEUE, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1,
                {ST_DELIVERED, 16'h0, 16'h0, 8'h0, 5'd0});
        // fill to capacity with ties and both priority extremes
        for (int i = 0; i < Q_DEPTH; i++)
            add_row({CMD_ENQUEUE, 16'(16'h0100 + i), 16'(16'hA000 + 16 * i),
                     fill_prio[i]}, 1'b0, '0);
        add_row({CMD_ENQUEUE, 16'hBEEF, 16'h1234, 8'h00}, 1'b1,
                {ST_FULL, 16'h0, 16'h0, 8'h0, 5'd16});
        // head of a full queue, then its tie in arrival order, then the next priority
        repeat (3) add_row({CMD_DEQUEUE, 16'h5555, 16'hAAAA, 8'h5A}, 1'b0, '0);

        // Reset is held, then released at a falling edge.
        send_idle_pct = 20;
        recv_idle_pct = 60;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_job(dir_rows[i].job, dir_rows[i].known, dir_rows[i].res);
        // sender pause: nothing offered until every result is back
        drop_and_drain();

        // Random part, three idle patterns: sender 20 / receiver 60,
        // sender 60 / receiver 20, then no idling at all.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 20 : 0;
            // long result hold-off while commands keep coming, so the
            // core fills its result register and stalls the input
            if (phase != 1)
                hold_req_seq++;
            enq_pct = 50;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                // new drift every 30 commands: toward full, balanced, empty
                if (n % 30 == 0)
                    case ($urandom_range(2))
                        0:       enq_pct = 85;
                        1:       enq_pct = 50;
                        default: enq_pct = 20;
                    endcase
                send_job(rand_job(enq_pct), 1'b0, '0);
            end
            drop_and_drain();
        end

        // Results are all in; let the core settle before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("** stable_priority_queue_core: PASSED **");
        end else begin
            $display("** stable_priority_queue_core: FAILED **");
        end
        $finish;
    end

endmodule
